### rtl/fasmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasmd_pkg
// shared types, constants and helpers for the fraction arithmetic pipeline
// ----------------------------------------------------------------------------
package fasmd_pkg;

    localparam int unsigned DATA_W       = 16;
    localparam int unsigned SHIFT_W      = 4;
    localparam int unsigned INV_W        = 17;
    localparam int unsigned GCD_STEPS    = 32;
    localparam int unsigned NEWTON_STEPS = 3;

    // one request as it travels through the gcd and inverse stages
    typedef struct packed {
        logic signed [DATA_W-1:0] na;
        logic signed [DATA_W-1:0] da;
        logic signed [DATA_W-1:0] nb;
        logic signed [DATA_W-1:0] db;
        logic [SHIFT_W-1:0]       k;
        logic [DATA_W-1:0]        u;
        logic [DATA_W-1:0]        v;
        logic [INV_W-1:0]         inv;
        logic [INV_W-1:0]         t;
    } pipe_t;

    // count of trailing zeros, zero for a zero word
    function automatic logic [SHIFT_W-1:0] ctz16(input logic [DATA_W-1:0] x);
        logic [SHIFT_W-1:0] r;
        r = '0;
        for (int i = DATA_W - 1; i >= 0; i--) begin
            if (x[i]) begin
                r = SHIFT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### rtl/fasmd_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasmd_prep
// entry stage: denominator magnitudes, common power of two, odd parts
// ----------------------------------------------------------------------------
module fasmd_prep
    import fasmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     valid_in,
    input  logic signed [DATA_W-1:0] num_a,
    input  logic signed [DATA_W-1:0] den_a,
    input  logic signed [DATA_W-1:0] num_b,
    input  logic signed [DATA_W-1:0] den_b,
    output logic                     valid_out,
    output pipe_t                    data_out
);

    logic        valid_reg;
    pipe_t       data_reg;
    pipe_t       data_next;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;

    always_comb
    begin
        ma = den_a[DATA_W-1] ? DATA_W'(-den_a) : den_a;
        mb = den_b[DATA_W-1] ? DATA_W'(-den_b) : den_b;
        data_next     = '0;
        data_next.na  = num_a;
        data_next.da  = den_a;
        data_next.nb  = num_b;
        data_next.db  = den_b;
        data_next.k   = ctz16(ma | mb);
        data_next.u   = ma >> ctz16(ma);
        data_next.v   = mb >> ctz16(mb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

### rtl/fasmd_gcd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasmd_gcd_step
// one binary gcd iteration on the odd parts: subtract and strip twos
// ----------------------------------------------------------------------------
module fasmd_gcd_step
    import fasmd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  pipe_t data_in,
    output logic  valid_out,
    output pipe_t data_out
);

    logic              valid_reg;
    pipe_t             data_reg;
    pipe_t             data_next;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] d;

    always_comb
    begin
        lo = (data_in.u < data_in.v) ? data_in.u : data_in.v;
        hi = (data_in.u < data_in.v) ? data_in.v : data_in.u;
        d  = hi - lo;
        data_next = data_in;
        // finished once v is zero
        if (data_in.v != '0)
        begin
            data_next.u = lo;
            data_next.v = d >> ctz16(d);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

### rtl/fasmd_inv_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasmd_inv_step
// one newton iteration for the inverse of the odd gcd modulo 2^17
// ----------------------------------------------------------------------------
module fasmd_inv_step
    import fasmd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  pipe_t data_in,
    output logic  valid_out,
    output pipe_t data_out
);

    logic                 valid1_reg;
    logic                 valid2_reg;
    pipe_t                data1_reg;
    pipe_t                data2_reg;
    pipe_t                data1_next;
    pipe_t                data2_next;
    logic [2*INV_W-1:0]   m1;
    logic [2*INV_W-1:0]   m2;

    // first half: t = g * inv
    always_comb
    begin
        m1 = {{INV_W{1'b0}}, INV_W'(data_in.u)} * {{INV_W{1'b0}}, data_in.inv};
        data1_next   = data_in;
        data1_next.t = m1[INV_W-1:0];
    end

    // second half: inv = inv * (2 - t)
    always_comb
    begin
        m2 = {{INV_W{1'b0}}, data1_reg.inv}
           * {{INV_W{1'b0}}, INV_W'(INV_W'(2) - data1_reg.t)};
        data2_next     = data1_reg;
        data2_next.inv = m2[INV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= valid_in;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data1_reg <= data1_next;
            data2_reg <= data2_next;
        end
    end

    assign valid_out = valid2_reg;
    assign data_out  = data2_reg;

endmodule

### rtl/fraction_add_sub_mul_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_sub_mul_div
// unreduced sum, difference, product and quotient of two signed fractions
// ----------------------------------------------------------------------------
// Pipeline of 42 register stages: a new request may enter every clock
// while the output is not stalled (sustained rate one per cycle). The
// depth is set by the binary gcd of the denominator magnitudes,
// 32 subtract-and-shift stages, followed by three newton iterations (six
// stages) for the inverse of the odd gcd modulo 2^17, which turns the exact
// divisions by the gcd into multiplies. A stall at the output freezes the
// whole pipeline; in_stall is raised for as long as that lasts. A zero
// denominator sets zero_den_error and forces sum_num, diff_num and
// common_den to zero; the plain products are still given.
// ----------------------------------------------------------------------------
module fraction_add_sub_mul_div
    import fasmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] num_a,
    input  logic signed [DATA_W-1:0] den_a,
    input  logic signed [DATA_W-1:0] num_b,
    input  logic signed [DATA_W-1:0] den_b,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [32:0]       sum_num,
    output logic signed [32:0]       diff_num,
    output logic signed [31:0]       common_den,
    output logic signed [31:0]       prod_num,
    output logic signed [31:0]       prod_den,
    output logic signed [31:0]       quot_num,
    output logic signed [31:0]       quot_den,
    output logic                     zero_den_error
);

    // global advance: move when the output register is free or being taken
    logic en;

    logic  g_valid [GCD_STEPS+1];
    pipe_t g_data  [GCD_STEPS+1];
    logic  n_valid [NEWTON_STEPS+1];
    pipe_t n_data  [NEWTON_STEPS+1];

    // scale stage
    logic                     sc_valid_reg;
    logic signed [DATA_W-1:0] sc_na_reg, sc_da_reg, sc_nb_reg, sc_db_reg;
    logic signed [INV_W-1:0]  sc_sa_reg, sc_sb_reg;
    logic signed [DATA_W-1:0] xa;
    logic signed [DATA_W-1:0] xb;
    logic [2*INV_W-1:0]       msa;
    logic [2*INV_W-1:0]       msb;

    // multiply stage
    logic               mu_valid_reg;
    logic signed [32:0] mu_pa_reg, mu_pb_reg;
    logic signed [31:0] mu_lden_reg;
    logic signed [31:0] mu_pn_reg, mu_pd_reg, mu_qn_reg, mu_qd_reg;
    logic               mu_err_reg;
    logic signed [32:0] pa_next, pb_next, lden_next;
    logic signed [31:0] pn_next, pd_next, qn_next, qd_next;

    // output register
    logic               out_valid_reg;
    logic signed [32:0] sum_reg, diff_reg;
    logic signed [31:0] lden_reg, pn_reg, pd_reg, qn_reg, qd_reg;
    logic               err_reg;
    logic signed [32:0] sum_next, diff_next;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    fasmd_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .valid_out (g_valid[0]),
        .data_out  (g_data[0])
    );

    // binary gcd, one iteration per stage
    for (genvar i = 0; i < GCD_STEPS; i++)
    begin : g_gcd
        fasmd_gcd_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (g_valid[i]),
            .data_in   (g_data[i]),
            .valid_out (g_valid[i+1]),
            .data_out  (g_data[i+1])
        );
    end

    // odd g is its own inverse to three bits, which seeds newton
    always_comb
    begin
        n_valid[0]    = g_valid[GCD_STEPS];
        n_data[0]     = g_data[GCD_STEPS];
        n_data[0].inv = INV_W'(g_data[GCD_STEPS].u);
    end

    for (genvar j = 0; j < NEWTON_STEPS; j++)
    begin : g_newton
        fasmd_inv_step u_inv (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (n_valid[j]),
            .data_in   (n_data[j]),
            .valid_out (n_valid[j+1]),
            .data_out  (n_data[j+1])
        );
    end

    // exact division by g: strip the power of two, multiply by inverse of odd part
    always_comb
    begin
        xa  = n_data[NEWTON_STEPS].db >>> n_data[NEWTON_STEPS].k;
        xb  = n_data[NEWTON_STEPS].da >>> n_data[NEWTON_STEPS].k;
        msa = {{INV_W{1'b0}}, {xa[DATA_W-1], xa}}
            * {{INV_W{1'b0}}, n_data[NEWTON_STEPS].inv};
        msb = {{INV_W{1'b0}}, {xb[DATA_W-1], xb}}
            * {{INV_W{1'b0}}, n_data[NEWTON_STEPS].inv};
    end

    // scaled numerators, common denominator and plain products
    always_comb
    begin
        pa_next   = 33'(sc_na_reg) * 33'(sc_sa_reg);
        pb_next   = 33'(sc_nb_reg) * 33'(sc_sb_reg);
        lden_next = 33'(sc_da_reg) * 33'(sc_sa_reg);
        pn_next   = 32'(sc_na_reg) * 32'(sc_nb_reg);
        pd_next   = 32'(sc_da_reg) * 32'(sc_db_reg);
        qn_next   = 32'(sc_na_reg) * 32'(sc_db_reg);
        qd_next   = 32'(sc_da_reg) * 32'(sc_nb_reg);
    end

    always_comb
    begin
        sum_next  = mu_pa_reg + mu_pb_reg;
        diff_next = mu_pa_reg - mu_pb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg  <= 1'b0;
            mu_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sc_valid_reg  <= n_valid[NEWTON_STEPS];
            mu_valid_reg  <= sc_valid_reg;
            out_valid_reg <= mu_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_na_reg   <= n_data[NEWTON_STEPS].na;
            sc_da_reg   <= n_data[NEWTON_STEPS].da;
            sc_nb_reg   <= n_data[NEWTON_STEPS].nb;
            sc_db_reg   <= n_data[NEWTON_STEPS].db;
            sc_sa_reg   <= msa[INV_W-1:0];
            sc_sb_reg   <= msb[INV_W-1:0];

            mu_pa_reg   <= pa_next;
            mu_pb_reg   <= pb_next;
            mu_lden_reg <= lden_next[31:0];
            mu_pn_reg   <= pn_next;
            mu_pd_reg   <= pd_next;
            mu_qn_reg   <= qn_next;
            mu_qd_reg   <= qd_next;
            mu_err_reg  <= (sc_da_reg == '0) || (sc_db_reg == '0);

            // zero denominator: gcd path is meaningless, force zeros
            sum_reg     <= mu_err_reg ? '0 : sum_next;
            diff_reg    <= mu_err_reg ? '0 : diff_next;
            lden_reg    <= mu_err_reg ? '0 : mu_lden_reg;
            pn_reg      <= mu_pn_reg;
            pd_reg      <= mu_pd_reg;
            qn_reg      <= mu_qn_reg;
            qd_reg      <= mu_qd_reg;
            err_reg     <= mu_err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sum_num        = sum_reg;
    assign diff_num       = diff_reg;
    assign common_den     = lden_reg;
    assign prod_num       = pn_reg;
    assign prod_den       = pd_reg;
    assign quot_num       = qn_reg;
    assign quot_den       = qd_reg;
    assign zero_den_error = err_reg;

endmodule

### rtl/fasmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasmd_checker
// port-level checks for the fraction arithmetic block
// ----------------------------------------------------------------------------
module fasmd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic signed [32:0] sum_num,
    input logic signed [32:0] diff_num,
    input logic signed [31:0] common_den,
    input logic              zero_den_error
);

    // a held result must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sum_num)
        && $stable(diff_num) && $stable(common_den))
        else $error("stalled result changed");

    // a blocked output backs up into the input
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request taken while output blocked");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_den_error |-> common_den == 0 && sum_num == 0
        && diff_num == 0)
        else $error("error result not cleared");

    a_lcm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_den_error |-> common_den != 0)
        else $error("zero common denominator without error");

endmodule

bind fraction_add_sub_mul_div fasmd_checker u_fasmd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sum_num        (sum_num),
    .diff_num       (diff_num),
    .common_den     (common_den),
    .zero_den_error (zero_den_error)
);

### verif/fraction_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_checker
// watches both channels, works out the expected fraction results for every
// accepted request and compares each accepted result field by field
// ----------------------------------------------------------------------------
module fraction_checker
    import fasmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [DATA_W-1:0] num_a,
    input  logic signed [DATA_W-1:0] den_a,
    input  logic signed [DATA_W-1:0] num_b,
    input  logic signed [DATA_W-1:0] den_b,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [32:0]       sum_num,
    input  logic signed [32:0]       diff_num,
    input  logic signed [31:0]       common_den,
    input  logic signed [31:0]       prod_num,
    input  logic signed [31:0]       prod_den,
    input  logic signed [31:0]       quot_num,
    input  logic signed [31:0]       quot_den,
    input  logic                     zero_den_error,
    output int                       fail_count,
    output int                       pending,
    output int                       result_count
);

    typedef struct {
        logic signed [32:0] sum;
        logic signed [32:0] diff;
        logic signed [31:0] lcm;
        logic signed [31:0] pn;
        logic signed [31:0] pd;
        logic signed [31:0] qn;
        logic signed [31:0] qd;
        logic               err;
    } frac_result_t;

    frac_result_t fraction_queue[$];

    function automatic longint gcd_mag(input longint p, input longint q);
        longint r;
        while (q != 0)
        begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    function automatic frac_result_t fraction_arith(input longint na, input longint da,
                                                    input longint nb, input longint db);
        frac_result_t r;
        longint g;
        r.sum  = '0;
        r.diff = '0;
        r.lcm  = '0;
        r.err  = (da == 0 || db == 0);
        if (!r.err)
        begin
            g      = gcd_mag(da < 0 ? -da : da, db < 0 ? -db : db);
            r.lcm  = 32'((da * db) / g);
            r.sum  = 33'(na * (db / g) + nb * (da / g));
            r.diff = 33'(na * (db / g) - nb * (da / g));
        end
        r.pn = 32'(na * nb);
        r.pd = 32'(da * db);
        r.qn = 32'(na * db);
        r.qd = 32'(da * nb);
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count   = 0;
        result_count = 0;
        pending      = 0;
    end

    always @(posedge clk)
    begin
        frac_result_t e;
        if (rst_n && in_valid && !in_stall)
            fraction_queue.push_back(fraction_arith(num_a, den_a, num_b, den_b));
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (fraction_queue.size() == 0)
                report("unexpected result", 0, 0);
            else
            begin
                e = fraction_queue.pop_front();
                if (sum_num !== e.sum)           report("sum_num", sum_num, e.sum);
                if (diff_num !== e.diff)         report("diff_num", diff_num, e.diff);
                if (common_den !== e.lcm)        report("common_den", common_den, e.lcm);
                if (prod_num !== e.pn)           report("prod_num", prod_num, e.pn);
                if (prod_den !== e.pd)           report("prod_den", prod_den, e.pd);
                if (quot_num !== e.qn)           report("quot_num", quot_num, e.qn);
                if (quot_den !== e.qd)           report("quot_den", quot_den, e.qd);
                if (zero_den_error !== e.err)    report("zero_den_error", zero_den_error, e.err);
            end
        end
        pending = fraction_queue.size();
    end

endmodule

### verif/fraction_add_sub_mul_div_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_sub_mul_div_test
// drives directed and random fraction pairs through the block with random
// gaps and stalls, plus one long output hold-off, and gives the verdict
// ----------------------------------------------------------------------------
module fraction_add_sub_mul_div_test;
    import fasmd_pkg::*;

    localparam int RANDOM_REQUESTS = 400;
    localparam int DRAIN_CYCLES    = 60;   // pipeline depth plus margin

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] num_a;
    logic signed [DATA_W-1:0] den_a;
    logic signed [DATA_W-1:0] num_b;
    logic signed [DATA_W-1:0] den_b;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [32:0]       sum_num;
    logic signed [32:0]       diff_num;
    logic signed [31:0]       common_den;
    logic signed [31:0]       prod_num;
    logic signed [31:0]       prod_den;
    logic signed [31:0]       quot_num;
    logic signed [31:0]       quot_den;
    logic                     zero_den_error;
    int                       fail_count;
    int                       pending;
    int                       result_count;
    int                       request_count;
    bit                       hold_done;   // long receiver hold-off has happened

    fraction_add_sub_mul_div u_top (.*);

    fraction_checker u_checker (.*);

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // random value leaning towards extremes and small magnitudes, so that
    // gcd paths and the zero-denominator case are hit often
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'(0);
            3:       return 16'($urandom_range(0, 16)) - 16'd8;
            4:       return 16'($urandom_range(1, 64)) << $urandom_range(0, 9);
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one request after a random gap and wait until it is taken
    task automatic send_request(input logic [15:0] na, input logic [15:0] da,
                                input logic [15:0] nb, input logic [15:0] db);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;                        // runs of back-to-back requests
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        num_a    <= na;
        den_a    <= da;
        num_b    <= nb;
        den_b    <= db;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        request_count++;
        @(negedge clk);
    endtask

    // receiver: random stall per result, and once a long hold-off while the
    // sender keeps offering so the pipeline fills and stalls its input
    initial
    begin
        int wait_cycles;
        out_stall = 1'b1;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && request_count >= 40)
            begin
                out_stall <= 1'b1;
                repeat (150) @(negedge clk);
                hold_done = 1'b1;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] ext[6];
        int          waited;
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0006};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        num_a         = '0;
        den_a         = '0;
        num_b         = '0;
        den_b         = '0;
        request_count = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extreme magnitudes, zero denominators, shared factors
        send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(16'h8000, 16'h0001, 16'h8000, 16'hffff);
        send_request(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_request(16'h0003, 16'h0000, 16'h0005, 16'h0007);
        send_request(16'h0003, 16'h0007, 16'h0005, 16'h0000);
        send_request(16'h8000, 16'h0000, 16'h7fff, 16'h0000);
        send_request(16'h0001, 16'h0006, 16'h0001, 16'h0004);
        send_request(16'hfffd, 16'hfff4, 16'h0005, 16'h0012);
        send_request(16'h0001, 16'h4000, 16'hffff, 16'h8000);
        send_request(16'h0000, 16'hfffe, 16'h0000, 16'h0003);
        send_request(16'h1234, 16'h0400, 16'hedcb, 16'hfc00);
        for (int i = 0; i < 6; i++)
            send_request(ext[i], ext[5 - i], ext[(i + 2) % 6], ext[(i + 4) % 6]);

        // random part
        for (int i = 0; i < RANDOM_REQUESTS; i++)
            send_request(pick_value(), pick_value(), pick_value(), pick_value());
        in_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("requests sent %0d, results checked %0d, long output hold-off %s",
                 request_count, result_count, hold_done ? "done" : "missed");
        $display("covered extremes, zero denominators, shared factors, random pairs");
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // overall limit
    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
rtl/fasmd_pkg.sv
rtl/fasmd_prep.sv
rtl/fasmd_gcd_step.sv
rtl/fasmd_inv_step.sv
rtl/fraction_add_sub_mul_div.sv
rtl/fasmd_checker.sv
verif/fraction_checker.sv
verif/fraction_add_sub_mul_div_test.sv
